### rtl/core/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg: shared types and constants of the delta-list timer queue
// Sizes, command and result codes, the word types of both channels and the
// request and response types of the entry store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dltq_pkg;

  localparam int NUM_ENTRIES = 32;
  localparam int MAX_OUT     = 32;
  localparam int ADDR_W      = $clog2(NUM_ENTRIES);
  localparam int IDX_W       = $clog2(NUM_ENTRIES + 1);
  localparam int CNT_MAX     = (NUM_ENTRIES > MAX_OUT) ? NUM_ENTRIES : MAX_OUT;
  localparam int CNT_W       = $clog2(CNT_MAX + 1);
  localparam int DELTA_W     = 16;
  localparam int FUNC_W      = 8;
  localparam int ARG_W       = 32;

  // The null link is the entry count itself.
  localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(NUM_ENTRIES);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_DRAIN  = 2'd2;
  localparam logic [1:0] CMD_RSVD   = 2'd3;

  localparam logic [2:0] KIND_INSERTED = 3'd0;
  localparam logic [2:0] KIND_OVERFLOW = 3'd1;
  localparam logic [2:0] KIND_TICK     = 3'd2;
  localparam logic [2:0] KIND_EXPIRED  = 3'd3;
  localparam logic [2:0] KIND_NONE     = 3'd4;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [FUNC_W-1:0]  func_id;
    logic [ARG_W-1:0]   arg_tag;
    logic [DELTA_W-1:0] delay_ticks;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [FUNC_W-1:0] exp_func_id;
    logic [ARG_W-1:0]  exp_arg_tag;
    logic              last;
  } out_word_t;

  // Write requests to the entry store; routine and argument share a port.
  typedef struct packed {
    logic               delta_we;
    logic [ADDR_W-1:0]  delta_addr;
    logic [DELTA_W-1:0] delta_data;
    logic               link_we;
    logic [ADDR_W-1:0]  link_addr;
    logic [IDX_W-1:0]   link_data;
    logic               ent_we;
    logic [ADDR_W-1:0]  ent_addr;
    logic [FUNC_W-1:0]  func_data;
    logic [ARG_W-1:0]   arg_data;
  } wr_req_t;

  // Registered read data of one entry.
  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic [IDX_W-1:0]   link;
    logic [FUNC_W-1:0]  func;
    logic [ARG_W-1:0]   arg;
  } rd_data_t;

  function automatic logic is_node(input logic [IDX_W-1:0] v);
    return v < NULL_IDX;
  endfunction

  // Any link at or beyond the entry count counts as null.
  function automatic logic [IDX_W-1:0] norm_link(input logic [IDX_W-1:0] v);
    return (v < NULL_IDX) ? v : NULL_IDX;
  endfunction

endpackage

`default_nettype wire

### rtl/core/dltq_store.sv
// ----------------------------------------------------------------------------
// dltq_store: entry store of the delta-list timer queue
// Delta, routine, argument and link arrays with one registered read port.
// Links that were never written read as the free chain in index order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dltq_store (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [dltq_pkg::ADDR_W-1:0] rd_addr_i,
  input  dltq_pkg::wr_req_t        wr_i,
  output dltq_pkg::rd_data_t       rd_o
);
  import dltq_pkg::*;

  logic [DELTA_W-1:0] delta_mem [NUM_ENTRIES];
  logic [FUNC_W-1:0]  func_mem  [NUM_ENTRIES];
  logic [ARG_W-1:0]   arg_mem   [NUM_ENTRIES];
  logic [IDX_W-1:0]   link_mem  [NUM_ENTRIES];

  logic [NUM_ENTRIES-1:0] link_vld_q;
  logic                   vld_rd_q;
  logic [ADDR_W-1:0]      addr_q;
  logic [DELTA_W-1:0]     delta_rd_q;
  logic [FUNC_W-1:0]      func_rd_q;
  logic [ARG_W-1:0]       arg_rd_q;
  logic [IDX_W-1:0]       link_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.delta_we) begin
      delta_mem[wr_i.delta_addr] <= wr_i.delta_data;
    end
    delta_rd_q <= delta_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.ent_we) begin
      func_mem[wr_i.ent_addr] <= wr_i.func_data;
      arg_mem[wr_i.ent_addr]  <= wr_i.arg_data;
    end
    func_rd_q <= func_mem[rd_addr_i];
    arg_rd_q  <= arg_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.link_we) begin
      link_mem[wr_i.link_addr] <= wr_i.link_data;
    end
    link_rd_q <= link_mem[rd_addr_i];
    addr_q    <= rd_addr_i;
  end

  // A cleared valid bit stands for the reset link of that entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
      vld_rd_q   <= 1'b0;
    end else begin
      if (wr_i.link_we) begin
        link_vld_q[wr_i.link_addr] <= 1'b1;
      end
      vld_rd_q <= link_vld_q[rd_addr_i];
    end
  end

  assign rd_o.delta = delta_rd_q;
  assign rd_o.func  = func_rd_q;
  assign rd_o.arg   = arg_rd_q;
  assign rd_o.link  = vld_rd_q ? link_rd_q : (IDX_W'(addr_q) + IDX_W'(1));

endmodule

`default_nettype wire

### rtl/core/delta_list_timer_queue.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue: callout timer queue kept as a delta-ordered list
// A pool of callout entries linked in expiry order, each holding its ticks
// beyond the entry before it; insert, tick and drain commands walk the list.
// ----------------------------------------------------------------------------
// Usage. Commands arrive as words on the input channel (valid/ready) and
// results leave as words on the output channel (valid/ready). An insert
// answers one word (inserted or overflow), a tick answers one word, and a
// drain answers one word per expired callout, up to 32, with last set on
// the final one, or a single nothing-expired word. The reserved command
// code is consumed and answers nothing. The halt register is written through
// cfg_we_i / cfg_wdata_i, by the user only while the block is idle (the block
// does not enforce this); when set, drains fire nothing.
// Timing. One command at a time; the entry store has a single registered
// read port and the sequencer reads one entry per cycle unless a drain
// waits on the receiver. An insert reads the taken entry's link, walks at
// most 31 entries, writes the links in two steps and answers; a tick reads
// the leading expired entries and the live one; a drain reads the fired
// callouts plus a live head that stops it, with one word per cycle while
// the receiver keeps up. An overflow, a halted drain and a tick or drain
// on an empty list answer without reading the store. Ready rises with the
// final word. Reset leaves the list empty with every entry on the free
// chain; no clearing pass is needed. When the receiver stalls, the finished
// word waits in the output register and the sequencer holds until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module delta_list_timer_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dltq_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dltq_pkg::out_word_t  out_data_o
);
  import dltq_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FREE  = 8'b0000_0010,
    S_WALK  = 8'b0000_0100,
    S_LINK1 = 8'b0000_1000,
    S_LINK2 = 8'b0001_0000,
    S_TICK  = 8'b0010_0000,
    S_DRAIN = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Sequencer registers.
  logic [IDX_W-1:0]   ptr_q, ptr_d;      // entry being read
  logic [IDX_W-1:0]   node_q, node_d;    // entry taken by an insert
  logic [IDX_W-1:0]   prev_q, prev_d;    // predecessor on the insert walk
  logic [DELTA_W-1:0] t_q, t_d;          // remaining insert delay
  logic [DELTA_W-1:0] dcur_q, dcur_d;    // delta of the insert successor
  logic [CNT_W-1:0]   cnt_q, cnt_d;      // walk steps or fired callouts
  logic [IDX_W-1:0]   head_q, head_d;
  logic [IDX_W-1:0]   free_q, free_d;
  logic               halted_q;
  logic               pend_q, pend_d;    // one fired callout held back
  logic [FUNC_W-1:0]  pend_func_q, pend_func_d;
  logic [ARG_W-1:0]   pend_arg_q, pend_arg_d;
  logic [2:0]         resp_kind_q, resp_kind_d;

  // Output register.
  logic      out_valid_q;
  out_word_t out_q;
  logic      out_load;
  out_word_t out_word;
  logic      out_free;

  // Entry store interface.
  wr_req_t  wr;
  rd_data_t rd;

  // The one shared subtractor; bit DELTA_W is the borrow.
  logic [DELTA_W-1:0] sub_a, sub_b;
  logic [DELTA_W:0]   sub_res;

  logic [IDX_W-1:0] nxt;
  logic [CNT_W-1:0] cnt_inc;

  assign sub_res  = {1'b0, sub_a} - {1'b0, sub_b};
  assign nxt      = norm_link(rd.link);
  assign cnt_inc  = cnt_q + CNT_W'(1);
  assign out_free = !out_valid_q || out_ready_i;

  dltq_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (ptr_d[ADDR_W-1:0]),
    .wr_i      (wr),
    .rd_o      (rd)
  );

  // The store always reads the entry that ptr will point to, so the read
  // data in any cycle belongs to ptr_q.
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    node_d      = node_q;
    prev_d      = prev_q;
    t_d         = t_q;
    dcur_d      = dcur_q;
    cnt_d       = cnt_q;
    head_d      = head_q;
    free_d      = free_q;
    pend_d      = pend_q;
    pend_func_d = pend_func_q;
    pend_arg_d  = pend_arg_q;
    resp_kind_d = resp_kind_q;
    wr          = '0;
    out_load    = 1'b0;
    out_word    = '0;
    sub_a       = '0;
    sub_b       = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.cmd)
            CMD_INSERT: begin
              if (!is_node(free_q)) begin
                resp_kind_d = KIND_OVERFLOW;
                state_d     = S_RESP;
              end else begin
                wr.ent_we    = 1'b1;
                wr.ent_addr  = free_q[ADDR_W-1:0];
                wr.func_data = in_data_i.func_id;
                wr.arg_data  = in_data_i.arg_tag;
                node_d       = free_q;
                ptr_d        = free_q;
                t_d          = in_data_i.delay_ticks;
                state_d      = S_FREE;
              end
            end
            CMD_TICK: begin
              resp_kind_d = KIND_TICK;
              cnt_d       = '0;
              if (!is_node(head_q)) begin
                state_d = S_RESP;
              end else begin
                ptr_d   = head_q;
                state_d = S_TICK;
              end
            end
            CMD_DRAIN: begin
              resp_kind_d = KIND_NONE;
              pend_d      = 1'b0;
              cnt_d       = '0;
              if (halted_q || !is_node(head_q)) begin
                state_d = S_RESP;
              end else begin
                ptr_d   = head_q;
                state_d = S_DRAIN;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // Read data holds the taken entry's link: it becomes the free head.
      S_FREE: begin
        free_d = nxt;
        prev_d = NULL_IDX;
        cnt_d  = '0;
        ptr_d  = head_q;
        state_d = is_node(head_q) ? S_WALK : S_LINK1;
      end

      // Pass entries whose delta is below the remaining delay.
      S_WALK: begin
        sub_a = t_q;
        sub_b = rd.delta;
        if (!sub_res[DELTA_W] && (sub_res[DELTA_W-1:0] != '0)) begin
          t_d    = sub_res[DELTA_W-1:0];
          prev_d = ptr_q;
          ptr_d  = nxt;
          cnt_d  = cnt_inc;
          if (!is_node(nxt) || (cnt_inc == CNT_W'(NUM_ENTRIES))) begin
            state_d = S_LINK1;
          end
        end else begin
          dcur_d  = rd.delta;
          state_d = S_LINK1;
        end
      end

      S_LINK1: begin
        wr.link_we    = 1'b1;
        wr.link_addr  = node_q[ADDR_W-1:0];
        wr.link_data  = ptr_q;
        wr.delta_we   = 1'b1;
        wr.delta_addr = node_q[ADDR_W-1:0];
        wr.delta_data = t_q;
        state_d       = S_LINK2;
      end

      S_LINK2: begin
        if (is_node(prev_q)) begin
          wr.link_we   = 1'b1;
          wr.link_addr = prev_q[ADDR_W-1:0];
          wr.link_data = node_q;
        end else begin
          head_d = node_q;
        end
        if (is_node(ptr_q)) begin
          sub_a         = dcur_q;
          sub_b         = t_q;
          wr.delta_we   = 1'b1;
          wr.delta_addr = ptr_q[ADDR_W-1:0];
          wr.delta_data = sub_res[DELTA_W-1:0];
        end
        resp_kind_d = KIND_INSERTED;
        state_d     = S_RESP;
      end

      // Skip leading expired entries, then count down the first live one.
      S_TICK: begin
        if (rd.delta == '0) begin
          cnt_d = cnt_inc;
          if (!is_node(nxt) || (cnt_inc == CNT_W'(NUM_ENTRIES))) begin
            state_d = S_RESP;
          end else begin
            ptr_d = nxt;
          end
        end else begin
          sub_a         = rd.delta;
          sub_b         = DELTA_W'(1);
          wr.delta_we   = 1'b1;
          wr.delta_addr = ptr_q[ADDR_W-1:0];
          wr.delta_data = sub_res[DELTA_W-1:0];
          state_d       = S_RESP;
        end
      end

      // Each fired callout is held back so that the last one can be
      // marked; the held one goes out when the next is found.
      S_DRAIN: begin
        if (rd.delta != '0) begin
          state_d = S_RESP;
        end else if (!pend_q || out_free) begin
          if (pend_q) begin
            out_load             = 1'b1;
            out_word.kind        = KIND_EXPIRED;
            out_word.exp_func_id = pend_func_q;
            out_word.exp_arg_tag = pend_arg_q;
            out_word.last        = 1'b0;
          end
          pend_d       = 1'b1;
          pend_func_d  = rd.func;
          pend_arg_d   = rd.arg;
          head_d       = nxt;
          wr.link_we   = 1'b1;
          wr.link_addr = ptr_q[ADDR_W-1:0];
          wr.link_data = free_q;
          free_d       = ptr_q;
          cnt_d        = cnt_inc;
          resp_kind_d  = KIND_EXPIRED;
          if (!is_node(nxt) || (cnt_inc == CNT_W'(MAX_OUT))) begin
            state_d = S_RESP;
          end else begin
            ptr_d = nxt;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_word.kind = resp_kind_q;
          out_word.last = 1'b1;
          if (resp_kind_q == KIND_EXPIRED) begin
            out_word.exp_func_id = pend_func_q;
            out_word.exp_arg_tag = pend_arg_q;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= NULL_IDX;
      cnt_q       <= '0;
      head_q      <= NULL_IDX;
      free_q      <= '0;
      halted_q    <= 1'b0;
      pend_q      <= 1'b0;
      resp_kind_q <= KIND_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      free_q      <= free_d;
      pend_q      <= pend_d;
      resp_kind_q <= resp_kind_d;
      if (cfg_we_i) begin
        halted_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    node_q      <= node_d;
    prev_q      <= prev_d;
    t_q         <= t_d;
    dcur_q      <= dcur_d;
    pend_func_q <= pend_func_d;
    pend_arg_q  <= pend_arg_d;
    if (out_load) begin
      out_q <= out_word;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### rtl/core/dltq_checker.sv
// ----------------------------------------------------------------------------
// dltq_checker: port-level checks of the delta-list timer queue
// Watches the channels of the top level over time; bound to it below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dltq_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_o,
  input  dltq_pkg::in_word_t  in_data_i,
  input  logic                out_valid_o,
  input  logic                out_ready_i,
  input  dltq_pkg::out_word_t out_data_o
);
  import dltq_pkg::*;

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // Any real command leaves the block not ready in the cycle after it is taken.
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.cmd != CMD_RSVD) |=> !in_ready_o)
    else $error("block ready right after taking a command");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.kind <= KIND_NONE)
    else $error("result kind out of range");

  // Only expired callouts come in groups and carry a routine and argument.
  a_single_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind != KIND_EXPIRED) |->
      out_data_o.last && (out_data_o.exp_func_id == '0) &&
      (out_data_o.exp_arg_tag == '0))
    else $error("non-expiry result without last or with payload");

endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the delta-list timer queue
// Commands go in through the valid/ready word channel. A shadow copy of the
// callout list, kept inside the bench, works out every result word at the
// moment a command is accepted. Each word that leaves the block is compared
// field by field with the oldest word still owed. Directed tests come first,
// then random phases under varying sender idling and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import dltq_pkg::*;

  // Clock, reset and the block's inputs, all known from time zero.
  logic      clk_i     = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_word   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_word_t out_word;

  // Idling in percent of cycles, changed from one phase to the next.
  int unsigned snd_idle_pct  = 0;
  int unsigned rcv_stall_pct = 0;
  int          err_count     = 0;

  // Shadow copy of the callout pool. Links use NULL_IDX as the end marker.
  logic [DELTA_W-1:0] shadow_delta [NUM_ENTRIES];
  logic [FUNC_W-1:0]  shadow_func  [NUM_ENTRIES];
  logic [ARG_W-1:0]   shadow_arg   [NUM_ENTRIES];
  logic [IDX_W-1:0]   shadow_link  [NUM_ENTRIES];
  logic [IDX_W-1:0]   shadow_active;
  logic [IDX_W-1:0]   shadow_free;
  logic               shadow_halted;

  // Result words owed by the block, oldest first.
  out_word_t callout_results_q [$];
  out_word_t want_word;

  delta_list_timer_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_word)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one accepted command to the shadow list and queue the words it
  // must produce. Runs in the time step of the accepting clock edge.
  function automatic void apply_command(input in_word_t w);
    logic [IDX_W-1:0]   node;
    logic [IDX_W-1:0]   prev;
    logic [IDX_W-1:0]   cur;
    logic [DELTA_W-1:0] remain;
    int                 steps;
    int                 fired;
    out_word_t          r;
    r      = '0;
    r.last = 1'b1;
    steps  = 0;
    case (w.cmd)
      CMD_INSERT: begin
        node = shadow_free;
        if (node >= NULL_IDX) begin
          // Pool exhausted: the insert is dropped and nothing moves.
          r.kind = KIND_OVERFLOW;
        end else begin
          shadow_free       = shadow_link[node];
          shadow_func[node] = w.func_id;
          shadow_arg[node]  = w.arg_tag;
          prev   = NULL_IDX;
          cur    = shadow_active;
          remain = w.delay_ticks;
          // Pass every entry that expires strictly earlier; a zero delay
          // therefore lands ahead of the leading zero-delta entries.
          while (cur < NULL_IDX && steps < NUM_ENTRIES && shadow_delta[cur] < remain) begin
            remain = remain - shadow_delta[cur];
            prev   = cur;
            cur    = shadow_link[cur];
            steps++;
          end
          if (cur >= NULL_IDX) cur = NULL_IDX;
          if (prev < NULL_IDX) shadow_link[prev] = node;
          else shadow_active = node;
          shadow_link[node]  = cur;
          shadow_delta[node] = remain;
          if (cur < NULL_IDX) shadow_delta[cur] = shadow_delta[cur] - remain;
          r.kind = KIND_INSERTED;
        end
        callout_results_q.push_back(r);
      end
      CMD_TICK: begin
        cur = shadow_active;
        while (cur < NULL_IDX && steps < NUM_ENTRIES && shadow_delta[cur] == '0) begin
          cur = shadow_link[cur];
          steps++;
        end
        if (cur < NULL_IDX && shadow_delta[cur] != '0) shadow_delta[cur] = shadow_delta[cur] - 1'b1;
        r.kind = KIND_TICK;
        callout_results_q.push_back(r);
      end
      CMD_DRAIN: begin
        fired = 0;
        if (!shadow_halted) begin
          while (fired < MAX_OUT && shadow_active < NULL_IDX &&
                 shadow_delta[shadow_active] == '0) begin
            node              = shadow_active;
            shadow_active     = (shadow_link[node] < NULL_IDX) ? shadow_link[node] : NULL_IDX;
            shadow_link[node] = shadow_free;
            shadow_free       = node;
            r.kind            = KIND_EXPIRED;
            r.exp_func_id     = shadow_func[node];
            r.exp_arg_tag     = shadow_arg[node];
            r.last            = 1'b0;
            callout_results_q.push_back(r);
            fired++;
          end
        end
        if (fired == 0) begin
          r      = '0;
          r.kind = KIND_NONE;
          r.last = 1'b1;
          callout_results_q.push_back(r);
        end else begin
          r      = callout_results_q.pop_back();
          r.last = 1'b1;
          callout_results_q.push_back(r);
        end
      end
      default: begin
        // The reserved code is swallowed without a word.
      end
    endcase
  endfunction

  function automatic int active_count();
    logic [IDX_W-1:0] cur;
    int               n;
    n   = 0;
    cur = shadow_active;
    while (cur < NULL_IDX && n < NUM_ENTRIES) begin
      cur = shadow_link[cur];
      n++;
    end
    return n;
  endfunction

  // Mostly short delays so that callouts really expire; a few medium ones
  // and now and then any 16-bit value so that every delay bit toggles.
  function automatic logic [DELTA_W-1:0] pick_delay();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 80) return DELTA_W'($urandom_range(0, 6));
    if (sel < 95) return DELTA_W'($urandom_range(7, 40));
    return DELTA_W'($urandom_range(0, 65535));
  endfunction

  // Fields that a command does not use still carry random bits.
  function automatic in_word_t random_word(input logic [1:0] cmd);
    in_word_t w;
    w.cmd         = cmd;
    w.func_id     = FUNC_W'($urandom);
    w.arg_tag     = $urandom;
    w.delay_ticks = pick_delay();
    return w;
  endfunction

  // Offer one word, with a random idle gap ahead of it, hold it until the
  // block takes it and then update the shadow list. Valid is written once
  // per time step: either lowered for a gap or raised for the new word.
  task automatic send_word(input in_word_t w);
    if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    apply_command(w);
  endtask

  task automatic send_insert(input logic [FUNC_W-1:0] fn, input logic [ARG_W-1:0] arg,
                             input logic [DELTA_W-1:0] delay);
    in_word_t w;
    w.cmd         = CMD_INSERT;
    w.func_id     = fn;
    w.arg_tag     = arg;
    w.delay_ticks = delay;
    send_word(w);
  endtask

  task automatic send_cmd(input logic [1:0] cmd);
    send_word(random_word(cmd));
  endtask

  // Let the block fall idle: every owed word back, then enough cycles for
  // a swallowed reserved command or the longest insert walk to finish.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (callout_results_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  // The halt register is only written while the block is quiet.
  task automatic write_halt(input logic value);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we        <= 1'b0;
    shadow_halted  = value;
  endtask

  task automatic set_idling(input int unsigned snd_pct, input int unsigned rcv_pct);
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
  endtask

  // Empty list: tick and drain find nothing, the reserved code is
  // swallowed, and a tick over a list of only zero deltas changes nothing.
  task automatic test_empty_list();
    send_cmd(CMD_TICK);
    send_cmd(CMD_DRAIN);
    send_cmd(CMD_RSVD);
    send_insert(8'h3C, 32'h0000_0001, 16'd0);
    send_cmd(CMD_TICK);
    send_cmd(CMD_DRAIN);
  endtask

  // Extremes of every field. The longest delay stays at the tail for good.
  task automatic test_field_extremes();
    send_insert(8'h00, 32'h0000_0000, 16'hFFFF);
    send_insert(8'hFF, 32'hFFFF_FFFF, 16'd0);
    send_cmd(CMD_DRAIN);
    send_cmd(CMD_TICK);
    send_cmd(CMD_DRAIN);
  endtask

  // Zero-delay inserts go ahead of every entry, expired or still counting;
  // a later insert with an equal delay goes ahead of the earlier one.
  task automatic test_zero_delay_order();
    send_insert(8'h11, 32'h1111_0003, 16'd3);
    send_insert(8'h22, 32'h2222_0000, 16'd0);
    send_insert(8'h33, 32'h3333_0003, 16'd3);
    send_insert(8'h44, 32'h4444_0000, 16'd0);
    send_insert(8'h55, 32'h5555_0001, 16'd1);
    send_cmd(CMD_DRAIN);
    send_cmd(CMD_TICK);
    send_cmd(CMD_DRAIN);
    send_cmd(CMD_TICK);
    send_cmd(CMD_TICK);
    send_cmd(CMD_DRAIN);
  endtask

  // While halted a drain reports nothing even with an expired callout at
  // the head; once released the same callout fires.
  task automatic test_halted_drain();
    write_halt(1'b1);
    send_insert(8'h96, 32'h6969_9696, 16'd0);
    send_cmd(CMD_DRAIN);
    write_halt(1'b0);
    send_cmd(CMD_DRAIN);
  endtask

  // Random mix of commands; reserved codes do not count toward the total.
  task automatic test_random_mix(input int n_cmds);
    int          done;
    int unsigned sel;
    done = 0;
    while (done < n_cmds) begin
      sel = $urandom_range(99);
      if (sel < 50) send_cmd(CMD_INSERT);
      else if (sel < 80) send_cmd(CMD_TICK);
      else if (sel < 95) send_cmd(CMD_DRAIN);
      else send_cmd(CMD_RSVD);
      if (sel < 95) done++;
    end
  endtask

  // Fill the pool past its end so that inserts overflow, then tick and
  // drain it back down; full drains return long bursts of words.
  task automatic test_pool_overflow();
    in_word_t w;
    int       n_free;
    n_free = NUM_ENTRIES - active_count();
    repeat (n_free + 2) begin
      w             = random_word(CMD_INSERT);
      w.delay_ticks = DELTA_W'($urandom_range(0, 4));
      send_word(w);
      if ($urandom_range(9) == 0) send_cmd(CMD_TICK);
    end
    repeat (6) begin
      repeat ($urandom_range(0, 2)) send_cmd(CMD_TICK);
      send_cmd(CMD_DRAIN);
    end
  endtask

  task automatic run_phase(input int unsigned snd_pct, input int unsigned rcv_pct);
    set_idling(snd_pct, rcv_pct);
    test_random_mix(30);
    test_pool_overflow();
    write_halt(1'b1);
    test_random_mix(8);
    write_halt(1'b0);
  endtask

  // The receiver stalls at random, cycle by cycle.
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // Every word the block hands over is matched against the oldest word owed.
  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && out_ready) begin
      if (callout_results_q.size() == 0) begin
        $error("unexpected result word: kind %0d func %0h arg %0h last %0d",
               out_word.kind, out_word.exp_func_id, out_word.exp_arg_tag, out_word.last);
        err_count++;
      end else begin
        want_word = callout_results_q.pop_front();
        if (out_word.kind !== want_word.kind) begin
          $error("kind: expected %0d, actual %0d", want_word.kind, out_word.kind);
          err_count++;
        end
        if (out_word.exp_func_id !== want_word.exp_func_id) begin
          $error("exp_func_id: expected %0h, actual %0h",
                 want_word.exp_func_id, out_word.exp_func_id);
          err_count++;
        end
        if (out_word.exp_arg_tag !== want_word.exp_arg_tag) begin
          $error("exp_arg_tag: expected %0h, actual %0h",
                 want_word.exp_arg_tag, out_word.exp_arg_tag);
          err_count++;
        end
        if (out_word.last !== want_word.last) begin
          $error("last: expected %0d, actual %0d", want_word.last, out_word.last);
          err_count++;
        end
      end
    end
  end

  initial begin
    // Shadow state after reset: empty list, every entry on the free chain.
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      shadow_delta[i] = '0;
      shadow_func[i]  = '0;
      shadow_arg[i]   = '0;
      shadow_link[i]  = IDX_W'(i + 1);
    end
    shadow_active = NULL_IDX;
    shadow_free   = '0;
    shadow_halted = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_field_extremes();
    test_zero_delay_order();
    test_halted_drain();

    // Random phases: no idling, a slow sender, a slow receiver, then both.
    run_phase(0, 0);
    run_phase(72, 0);
    run_phase(0, 72);
    run_phase(32, 32);

    wait_quiet();
    if (callout_results_q.size() != 0) begin
      $error("%0d result words never arrived", callout_results_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Safety net in case the block stops answering.
  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
